### src/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF  = 16;
  localparam int unsigned PRIORITY_BITS    = 8;
  localparam int unsigned PAYLOAD_BITS     = 32;
  localparam int unsigned COUNT_FIELD_BITS = 5;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL_DROP = 2'd1,
    STATUS_EMPTY_DEQ = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_HOLD = 1'b1
  } state_e;

  typedef struct packed {
    op_e                      operation;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [PAYLOAD_BITS-1:0]  payload;
  } spq_in_t;

  typedef struct packed {
    logic                        out_valid;
    logic [PRIORITY_BITS-1:0]    out_priority;
    logic [PAYLOAD_BITS-1:0]     out_payload;
    logic [COUNT_FIELD_BITS-1:0] entry_count;
    logic                        queue_empty;
    status_e                     status;
  } spq_out_t;

  typedef struct packed {
    logic    enq;
    logic    deq;
    logic    load;
    status_e status;
  } spq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

`default_nettype wire

### src/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  spq_pkg::op_e     op_i,
  input  wire              out_stall_i,
  input  spq_pkg::spq_stat_t stat_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output spq_pkg::spq_cmd_t cmd_o
);
  import spq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) begin
          state_d = ST_HOLD;
        end else if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        out_valid_o = 1'b0;
      end
      ST_HOLD: begin
        in_stall_o  = out_stall_i;
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.enq    = accept && (op_i == OP_ENQUEUE) && !stat_i.full;
    cmd_o.deq    = accept && (op_i == OP_DEQUEUE) && !stat_i.empty;
    cmd_o.status = STATUS_OK;
    if (op_i == OP_ENQUEUE && stat_i.full) begin
      cmd_o.status = STATUS_FULL_DROP;
    end else if (op_i == OP_DEQUEUE && stat_i.empty) begin
      cmd_o.status = STATUS_EMPTY_DEQ;
    end
  end

endmodule

`default_nettype wire

### src/spq_datapath.sv
`default_nettype none

module spq_datapath #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  spq_pkg::spq_in_t   in_data_i,
  input  spq_pkg::spq_cmd_t  cmd_i,
  output spq_pkg::spq_stat_t stat_o,
  output spq_pkg::spq_out_t  out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PRIORITY_BITS-1:0] prio_q [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  data_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   go;
  logic [CNT_W-1:0]         count_q, count_d;
  spq_out_t                 result_q, result_d;

  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [PRIORITY_BITS-1:0] prio_d;
    logic [PAYLOAD_BITS-1:0]  data_d;
    logic                     from_prev;
    logic                     has_next;

    assign go[i] = (CNT_W'(i) >= count_q) || (prio_q[i] < in_data_i.priority_req);

    if (i == 0) begin : g_head
      assign from_prev = 1'b0;
    end else begin : g_body
      assign from_prev = go[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign has_next = 1'b0;
    end else begin : g_inner
      assign has_next = 1'b1;
    end

    always_comb begin
      prio_d = prio_q[i];
      data_d = data_q[i];
      if (cmd_i.enq && go[i]) begin
        if (from_prev) begin
          prio_d = prio_q[(i == 0) ? 0 : i - 1];
          data_d = data_q[(i == 0) ? 0 : i - 1];
        end else begin
          prio_d = in_data_i.priority_req;
          data_d = in_data_i.payload;
        end
      end else if (cmd_i.deq && has_next) begin
        prio_d = prio_q[(i == QUEUE_DEPTH - 1) ? i : i + 1];
        data_d = data_q[(i == QUEUE_DEPTH - 1) ? i : i + 1];
      end
    end

    always_ff @(posedge clk_i) begin
      prio_q[i] <= prio_d;
      data_q[i] <= data_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    result_d              = result_q;
    if (cmd_i.load) begin
      result_d.out_valid    = cmd_i.deq;
      result_d.out_priority = cmd_i.deq ? prio_q[0] : '0;
      result_d.out_payload  = cmd_i.deq ? data_q[0] : '0;
      result_d.entry_count  = COUNT_FIELD_BITS'(count_d);
      result_d.queue_empty  = (count_d == '0);
      result_d.status       = cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_data_o = result_q;

endmodule

`default_nettype wire

### src/stable_priority_queue_unit.sv
// Stable priority queue: a sorted store of up to QUEUE_DEPTH entries, highest
// priority at the front, equal priorities kept in arrival order.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is one
// enqueue or dequeue. Output channel (out_valid_o / out_stall_i / out_data_o):
// exactly one result transaction per input transaction, in order.
// The result is registered and shown in the cycle after the input is taken.
// Throughput: one transaction per cycle unless the receiver stalls; every cell
// of the shifting store compares its priority against the request in parallel
// and shifts in the same cycle, so the store update sets the cycle.
// The result register parts the channels: a new input is taken while a result
// waits, unless the receiver stalls, in which case in_stall_o follows
// out_stall_i and the pending result holds unchanged.
// Reset empties the queue (count zero) and drops any pending result; stored
// entries are not cleared, only slots below the count are ever read.
// A full enqueue is dropped with status 1; an empty dequeue returns zeros with
// status 2.
`default_nettype none

module stable_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::spq_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (in_data_i.operation),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

### tb/spq_order_checker.sv
module spq_order_checker #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  spq_pkg::spq_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  spq_pkg::spq_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  logic [PRIORITY_BITS-1:0] store_prio [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  store_tag  [QUEUE_DEPTH];
  int                       held;
  spq_out_t                 expected_reports [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    held         = 0;
  end

  task automatic apply_to_store(input spq_in_t req, output spq_out_t res);
    int slot;
    int k;
    res        = '0;
    res.status = STATUS_OK;
    if (req.operation == OP_ENQUEUE) begin
      if (held >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL_DROP;
      end else begin
        slot = held;
        for (k = 0; k < held; k++) begin
          if (store_prio[k] < req.priority_req) begin
            slot = k;
            break;
          end
        end
        for (k = held; k > slot; k--) begin
          store_prio[k] = store_prio[k-1];
          store_tag[k]  = store_tag[k-1];
        end
        store_prio[slot] = req.priority_req;
        store_tag[slot]  = req.payload;
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = STATUS_EMPTY_DEQ;
      end else begin
        res.out_valid    = 1'b1;
        res.out_priority = store_prio[0];
        res.out_payload  = store_tag[0];
        for (k = 1; k < held; k++) begin
          store_prio[k-1] = store_prio[k];
          store_tag[k-1]  = store_tag[k];
        end
        held--;
      end
    end
    res.entry_count = COUNT_FIELD_BITS'(held);
    res.queue_empty = (held == 0);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    spq_out_t want;
    spq_out_t res;
    if (!rst_ni) begin
      held = 0;
      expected_reports.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual 0x%0h",
                   $time, out_data_i);
          fail_count_o++;
        end else begin
          want = expected_reports.pop_front();
          check_field("out_valid", 32'(want.out_valid), 32'(out_data_i.out_valid));
          check_field("out_priority", 32'(want.out_priority), 32'(out_data_i.out_priority));
          check_field("out_payload", 32'(want.out_payload), 32'(out_data_i.out_payload));
          check_field("entry_count", 32'(want.entry_count), 32'(out_data_i.entry_count));
          check_field("queue_empty", 32'(want.queue_empty), 32'(out_data_i.queue_empty));
          check_field("status", 32'(want.status), 32'(out_data_i.status));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_to_store(in_data_i, res);
        expected_reports.push_back(res);
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

### tb/stable_priority_queue_unit_tb.sv
module stable_priority_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  spq_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  spq_out_t out_data_o;
  int       fail_count;
  int       pending;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  stable_priority_queue_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  spq_order_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic spq_in_t op_item(input op_e op, input logic [PRIORITY_BITS-1:0] prio,
                                      input logic [PAYLOAD_BITS-1:0] tag);
    spq_in_t item;
    item.operation    = op;
    item.priority_req = prio;
    item.payload      = tag;
    return item;
  endfunction

  function automatic spq_in_t random_item(input int enq_pct);
    spq_in_t item;
    int      pick;
    item.operation = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
    pick = $urandom_range(99);
    if (pick < 40) begin
      item.priority_req = PRIORITY_BITS'($urandom_range(3));
    end else if (pick < 50) begin
      item.priority_req = $urandom_range(1) ? '1 : '0;
    end else begin
      item.priority_req = PRIORITY_BITS'($urandom_range(255));
    end
    item.payload = $urandom;
    return item;
  endfunction

  task automatic send_item(input spq_in_t item, input bit may_idle);
    while (may_idle && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    int cyc;
    cyc = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if ((cyc >= 300 && cyc < 380) || (cyc >= 1500 && cyc < 1560)) begin
        out_stall_i <= 1'b1;
      end else if (cyc >= 2000 && cyc < 3000) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 20);
      end
    end
  end

  initial begin : stimulus
    int fill_bias [5] = '{95, 70, 50, 30, 10};
    int enq_pct;
    int n;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(op_item(OP_DEQUEUE, '1, '1), 1'b1);
    send_item(op_item(OP_ENQUEUE, '1, '1), 1'b1);
    send_item(op_item(OP_ENQUEUE, '0, '0), 1'b1);
    send_item(op_item(OP_ENQUEUE, 8'd128, 32'h0000_00a1), 1'b1);
    send_item(op_item(OP_ENQUEUE, 8'd128, 32'h0000_00a2), 1'b1);
    send_item(op_item(OP_ENQUEUE, 8'd128, 32'h0000_00a3), 1'b1);
    send_item(op_item(OP_ENQUEUE, '0, 32'h5555_5555), 1'b1);
    send_item(op_item(OP_ENQUEUE, '1, 32'haaaa_aaaa), 1'b1);
    send_item(op_item(OP_ENQUEUE, 8'd200, 32'h1234_5678), 1'b1);
    repeat (9) send_item(op_item(OP_DEQUEUE, '0, '0), 1'b1);
    drain_results();

    enq_pct = 95;
    for (n = 0; n < 1232; n++) begin
      if (n % 40 == 0 && n != 0) enq_pct = fill_bias[$urandom_range(4)];
      if (n == 600 || n == 1000) drain_results();
      send_item(random_item(enq_pct), !(n >= 400 && n < 700));
    end
    drain_results();
    repeat (4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("stable_priority_queue_unit regression: pass");
    end else begin
      $display("stable_priority_queue_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("stable_priority_queue_unit regression: fail");
    $finish;
  end

endmodule

### filelist.f
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/stable_priority_queue_unit.sv
tb/spq_order_checker.sv
tb/stable_priority_queue_unit_tb.sv
